@@ hdl/gic_pkg.sv @@
package gic_pkg;

    // default sizes of the button and axis stores
    localparam int NUM_BUTTONS_DEF = 24;
    localparam int NUM_AXES_DEF    = 6;

    // stream widths: fields packed from bit 0, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // fixed button and axis numbers
    localparam int BTN_LT    = 10;
    localparam int BTN_RT    = 11;
    localparam int BTN_DPAD0 = 12;
    localparam int AXIS_LT   = 4;
    localparam int AXIS_RT   = 5;

    localparam logic [14:0] DEADZONE_RST  = 15'd5898;
    localparam logic [14:0] THRESHOLD_RST = 15'd11469;
    localparam logic [15:0] GAIN_RST      = 16'd19980;

    localparam logic signed [15:0] FULL_SCALE = 16'sd32767;

    typedef enum logic [2:0] {
        FUNC_FRAME   = 3'd0,
        FUNC_BUTTON  = 3'd1,
        FUNC_AXIS    = 3'd2,
        FUNC_HAT     = 3'd3,
        FUNC_TRIGGER = 3'd4,
        FUNC_CONNECT = 3'd5,
        FUNC_QUERY   = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        SRC_NONE   = 3'd0,
        SRC_BUTTON = 3'd1,
        SRC_POS    = 3'd2,
        SRC_NEG    = 3'd3,
        SRC_FULL   = 3'd4
    } src_t;

    typedef enum logic [1:0] {
        REG_DEADZONE  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_GAIN      = 2'd2
    } cfg_reg_t;

    // deadzone cut and rescale of a Q1.15 sample, round half up, saturated
    function automatic logic signed [15:0] dz_apply(
        input logic signed [15:0] a,
        input logic [14:0]        dz,
        input logic [15:0]        gain
    );
        logic signed [15:0] neg_a;
        logic [14:0] mag;
        logic [14:0] diff;
        logic [30:0] prod;
        logic [31:0] rnd;
        logic [17:0] scaled;
        logic [14:0] sat;
        logic signed [15:0] pos_val;
        neg_a = -a;
        mag = a[15] ? neg_a[14:0] : a[14:0];
        diff = mag - dz;
        prod = 31'(diff) * 31'(gain);
        rnd = {1'b0, prod} + 32'd8192;
        scaled = rnd[31:14];
        sat = (scaled > 18'd32767) ? 15'h7fff : scaled[14:0];
        pos_val = $signed({1'b0, sat});
        if (mag < dz) begin
            return 16'sd0;
        end
        return a[15] ? -pos_val : pos_val;
    endfunction

    // axis binding held test against the trigger threshold
    function automatic logic axis_held(
        input src_t               src,
        input logic signed [15:0] v,
        input logic [14:0]        t
    );
        logic signed [16:0] vx;
        logic signed [16:0] tx;
        logic signed [16:0] sum;
        logic above;
        logic below;
        vx = {v[15], v};
        tx = $signed({2'b00, t});
        sum = vx + tx;
        above = vx > tx;
        below = sum[16];
        case (src)
            SRC_POS:  return above;
            SRC_NEG:  return below;
            SRC_FULL: return above | below;
            default:  return 1'b0;
        endcase
    endfunction

endpackage

@@ hdl/gamepad_input_conditioner_core.sv @@
// Gamepad input conditioner. Each slave beat is one controller event selected by
// s_tuser (frame start, button level, axis sample, hat, trigger sync, connect,
// binding query) and produces exactly one master beat, all zero except for a
// binding query, which returns down, pressed, released and the deadzone-rescaled
// analog value. Events are taken one per clock while m_tready does not hold the
// result register: a beat sits in the input register while the button and axis
// state update and the query answer is formed, then moves to the result register
// and shows on the master side; the next event may be accepted in the same cycle
// that the last one moves on. The input register stage holds the query path (axis
// select, deadzone subtract, one 15x16 multiply per axis store, threshold compare).
// State needs no clearing pass: all of it sits in flip-flops cleared by reset.
// Registers are written through the cfg channel, which is always ready; the user
// must write them while no event is in flight, as the block does not enforce it.
module gamepad_input_conditioner_core #(
    parameter int NUM_BUTTONS = gic_pkg::NUM_BUTTONS_DEF,
    parameter int NUM_AXES    = gic_pkg::NUM_AXES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // events
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // index[4:0], level[5], hat_bits[9:6], axis_value[26:10], bind_source[29:27]
    input  logic [gic_pkg::S_TDATA_W-1:0] s_tdata,
    // func[2:0]
    input  logic [gic_pkg::S_TUSER_W-1:0] s_tuser,
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bind_down[0], bind_pressed[1], bind_released[2], bind_value[18:3]
    output logic [gic_pkg::M_TDATA_W-1:0] m_tdata,
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gic_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gic_pkg::*;

    localparam int AX_IW = $clog2(NUM_AXES);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [14:0] deadzone_reg;
    logic [14:0] threshold_reg;
    logic [15:0] gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg  <= DEADZONE_RST;
            threshold_reg <= THRESHOLD_RST;
            gain_reg      <= GAIN_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_DEADZONE:  deadzone_reg  <= cfg_data[14:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[14:0];
                REG_GAIN:      gain_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input register and handshake
    // ---------------------------------------------------------------
    logic               in_valid_reg;
    logic               out_valid_reg;
    func_t              in_func_reg;
    logic [4:0]         in_index_reg;
    logic               in_level_reg;
    logic [3:0]         in_hat_reg;
    logic signed [16:0] in_axis_reg;
    src_t               in_src_reg;
    logic               fire;
    logic               s_accept;

    // the event in the input register retires when the result slot is free
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_func_reg  <= func_t'(s_tuser[2:0]);
            in_index_reg <= s_tdata[4:0];
            in_level_reg <= s_tdata[5];
            in_hat_reg   <= s_tdata[9:6];
            in_axis_reg  <= $signed(s_tdata[26:10]);
            in_src_reg   <= src_t'(s_tdata[29:27]);
        end
    end

    // ---------------------------------------------------------------
    // controller state
    // ---------------------------------------------------------------
    logic                   connected_reg, connected_next;
    logic [NUM_BUTTONS-1:0] level_reg, level_next;
    logic [NUM_BUTTONS-1:0] press_reg, press_next;
    logic [NUM_BUTTONS-1:0] release_reg, release_next;
    logic signed [15:0]     axis_now_reg [NUM_AXES];
    logic signed [15:0]     axis_now_next [NUM_AXES];
    logic signed [15:0]     axis_before_reg [NUM_AXES];
    logic signed [15:0]     axis_before_next [NUM_AXES];

    // one-hot decode of the button number; numbers past the store hit nothing
    logic [NUM_BUTTONS-1:0] btn_hit;
    logic                   axis_in_range;
    logic [AX_IW-1:0]       axis_sel;

    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            btn_hit[i] = (in_index_reg == 5'(i));
        end
    end

    assign axis_in_range = (32'(in_index_reg) < NUM_AXES);
    assign axis_sel      = in_index_reg[AX_IW-1:0];

    // trigger hysteresis: on above threshold, off below half of it
    logic lt_on, lt_off, rt_on, rt_off;

    assign lt_on  = axis_now_reg[AXIS_LT] > $signed({1'b0, threshold_reg});
    assign lt_off = $signed({axis_now_reg[AXIS_LT], 1'b0}) < $signed({2'b00, threshold_reg});
    assign rt_on  = axis_now_reg[AXIS_RT] > $signed({1'b0, threshold_reg});
    assign rt_off = $signed({axis_now_reg[AXIS_RT], 1'b0}) < $signed({2'b00, threshold_reg});

    // buttons driven by this event and the level each is driven to
    logic [NUM_BUTTONS-1:0] feed_mask;
    logic [NUM_BUTTONS-1:0] feed_val;

    always_comb begin
        feed_mask = '0;
        feed_val  = '0;
        unique case (in_func_reg)
            FUNC_BUTTON: begin
                feed_mask = btn_hit;
                feed_val  = {NUM_BUTTONS{in_level_reg}};
            end
            FUNC_HAT: begin
                // d-pad buttons past the store are dropped
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    if (i >= BTN_DPAD0 && i < BTN_DPAD0 + 4) begin
                        feed_mask[i] = 1'b1;
                        feed_val[i]  = in_hat_reg[2'(i - BTN_DPAD0)];
                    end
                end
            end
            FUNC_TRIGGER: begin
                feed_mask[BTN_LT] = lt_on | lt_off;
                feed_val[BTN_LT]  = lt_on;
                feed_mask[BTN_RT] = rt_on | rt_off;
                feed_val[BTN_RT]  = rt_on;
            end
            default: ;
        endcase
    end

    // clamp of an axis sample to plus or minus full scale
    logic signed [15:0] axis_clamped;

    always_comb begin
        if (in_axis_reg > 17'sd32767) begin
            axis_clamped = FULL_SCALE;
        end else if (in_axis_reg < -17'sd32767) begin
            axis_clamped = -FULL_SCALE;
        end else begin
            axis_clamped = in_axis_reg[15:0];
        end
    end

    always_comb begin
        connected_next   = connected_reg;
        level_next       = (level_reg & ~feed_mask) | (feed_val & feed_mask);
        press_next       = press_reg | (feed_mask & feed_val & ~level_reg);
        release_next     = release_reg | (feed_mask & ~feed_val & level_reg);
        axis_now_next    = axis_now_reg;
        axis_before_next = axis_before_reg;
        unique case (in_func_reg)
            FUNC_FRAME: begin
                press_next       = '0;
                release_next     = '0;
                axis_before_next = axis_now_reg;
            end
            FUNC_AXIS: begin
                if (axis_in_range) begin
                    axis_now_next[axis_sel] = axis_clamped;
                end
            end
            FUNC_CONNECT: begin
                // a disconnect drops every button and axis
                if (!in_level_reg && connected_reg) begin
                    level_next   = '0;
                    press_next   = '0;
                    release_next = '0;
                    for (int i = 0; i < NUM_AXES; i++) begin
                        axis_now_next[i]    = '0;
                        axis_before_next[i] = '0;
                    end
                end
                connected_next = in_level_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            connected_reg <= 1'b0;
            level_reg     <= '0;
            press_reg     <= '0;
            release_reg   <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                axis_now_reg[i]    <= '0;
                axis_before_reg[i] <= '0;
            end
        end else if (fire) begin
            connected_reg   <= connected_next;
            level_reg       <= level_next;
            press_reg       <= press_next;
            release_reg     <= release_next;
            axis_now_reg    <= axis_now_next;
            axis_before_reg <= axis_before_next;
        end
    end

    // ---------------------------------------------------------------
    // binding query
    // ---------------------------------------------------------------
    logic signed [15:0] raw_now, raw_before;
    logic signed [15:0] v_now, v_before;
    logic               held_now, held_before;
    logic               q_down, q_pressed, q_released;
    logic signed [15:0] q_value;

    // out-of-range axes read as centered, which is never held
    assign raw_now    = axis_in_range ? axis_now_reg[axis_sel] : 16'sd0;
    assign raw_before = axis_in_range ? axis_before_reg[axis_sel] : 16'sd0;
    assign v_now      = dz_apply(raw_now, deadzone_reg, gain_reg);
    assign v_before   = dz_apply(raw_before, deadzone_reg, gain_reg);
    assign held_now    = axis_held(in_src_reg, v_now, threshold_reg);
    assign held_before = axis_held(in_src_reg, v_before, threshold_reg);

    always_comb begin
        q_down     = 1'b0;
        q_pressed  = 1'b0;
        q_released = 1'b0;
        q_value    = 16'sd0;
        if (in_func_reg == FUNC_QUERY) begin
            unique case (in_src_reg) inside
                SRC_BUTTON: begin
                    q_down     = |(level_reg & btn_hit);
                    q_pressed  = |(press_reg & btn_hit);
                    q_released = |(release_reg & btn_hit);
                    q_value    = q_down ? FULL_SCALE : 16'sd0;
                end
                SRC_POS, SRC_NEG, SRC_FULL: begin
                    q_down = held_now;
                    // trigger axes report the edges of their trigger buttons
                    if (in_index_reg == 5'(AXIS_LT)) begin
                        q_pressed  = press_reg[BTN_LT];
                        q_released = release_reg[BTN_LT];
                    end else if (in_index_reg == 5'(AXIS_RT)) begin
                        q_pressed  = press_reg[BTN_RT];
                        q_released = release_reg[BTN_RT];
                    end else begin
                        q_pressed  = held_now && !held_before;
                        q_released = !held_now && held_before;
                    end
                    case (in_src_reg)
                        SRC_POS: q_value = v_now[15] ? 16'sd0 : v_now;
                        SRC_NEG: q_value = v_now[15] ? -v_now : 16'sd0;
                        default: q_value = v_now;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic               down_reg, pressed_reg, released_reg;
    logic signed [15:0] value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            down_reg     <= q_down;
            pressed_reg  <= q_pressed;
            released_reg <= q_released;
            value_reg    <= q_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, value_reg, released_reg, pressed_reg, down_reg};

endmodule

@@ hdl/gic_checker.sv @@
module gic_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gic_pkg::M_TDATA_W-1:0] m_tdata
);
    import gic_pkg::*;

    // beats accepted but not yet delivered
    logic [1:0] cnt_reg, cnt_next;

    always_comb begin
        cnt_next = cnt_reg + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // no result without an event behind it
    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> cnt_reg != 2'd0)
        else $error("result beat with no event outstanding");

    // at most the input and result registers hold events
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("more than two events in flight");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // the value stays symmetric around zero
    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:3] != 16'h8000)
        else $error("bind value out of range");

endmodule

bind gamepad_input_conditioner_core gic_checker u_gic_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
